// ===== hw/rtl/swv_pkg.sv =====
// Shared widths, reset values, codes and control types of the swept wah filter.
package swv_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W    = 16;
  localparam int STATE_W     = 32;
  localparam int FRAC_W      = STATE_W - 8;
  localparam int SHIFT_BASE  = FRAC_W - (SAMPLE_W - 1);
  localparam int ACC_W       = STATE_W + 4;
  localparam int COEFF_W     = 18;
  localparam int DAMP_W      = 15;
  localparam int FREQ_W      = 32;
  localparam int STEP_W      = 24;
  localparam int OSHIFT_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SINE_ADDR_W = 10;

  // Configuration reset values.
  localparam logic [FREQ_W-1:0]   RESET_MIN_FREQ = FREQ_W'(48695777);
  localparam logic [FREQ_W-1:0]   RESET_MAX_FREQ = FREQ_W'(292174664);
  localparam logic [STEP_W-1:0]   RESET_STEP     = STEP_W'(4417);
  localparam logic [DAMP_W-1:0]   RESET_DAMP     = DAMP_W'(1638);
  localparam logic [OSHIFT_W-1:0] RESET_OSHIFT   = OSHIFT_W'(4);

  // Node saturation limits, sign-extended to the accumulator width.
  localparam logic signed [ACC_W-1:0] SAT_POS = ACC_W'((longint'(1) <<< (STATE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_NEG = ACC_W'(-(longint'(1) <<< (STATE_W - 1)));

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_FREQ = 3'd0,
    CFG_MAX_FREQ = 3'd1,
    CFG_STEP     = 3'd2,
    CFG_DAMP     = 3'd3,
    CFG_OSHIFT   = 3'd4
  } cfg_idx_e;

  // Operations of the shared multiply/add unit.
  typedef enum logic [2:0] {
    ALU_MULD,
    ALU_MULF,
    ALU_SUB,
    ALU_SUBSAT,
    ALU_ADDSAT
  } alu_op_e;

  // Filter sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MULD,
    S_XL,
    S_HP,
    S_MULF1,
    S_BP,
    S_MULF2,
    S_LP,
    S_OUT
  } seq_state_e;

  typedef struct packed {
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic [FREQ_W-1:0] min_freq;
    logic [FREQ_W-1:0] max_freq;
    logic [STEP_W-1:0] step;
  } sweep_cfg_t;

endpackage

// ===== hw/rtl/swept_state_variable_wah.sv =====
// Top level of the swept wah filter: configuration, sequencer, filter nodes and output.
//
// Wah-wah effect on a stream of signed Q1.15 samples: each beat goes through
// a state-variable filter whose bandpass node, shifted right by 9 plus
// output_shift bits and saturated to 16 bits, is returned with a clip flag.
// One shared multiplier and saturating adder evaluate the filter in seven
// steps under a small sequencer, and one more step forms the output, a
// step that waits while an earlier result is still untaken; a new sample
// is accepted only after that step. in_ready_o is high only while the sequencer
// is idle; the output register lets the next sample start while a result
// still waits. The center frequency sweeps between min and max by
// sweep_step once per sample; its coefficient comes from a 1025-entry
// table and takes effect one sample late. Registers are written through
// cfg_we_i, cfg_index_i and cfg_data_i and should change only while idle.
module swept_state_variable_wah import swv_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       clipped_o
);

  localparam int AMT_W = 5;

  seq_state_e state_q, state_d;

  logic [FREQ_W-1:0]   min_freq_q;
  logic [FREQ_W-1:0]   max_freq_q;
  logic [STEP_W-1:0]   step_q;
  logic [DAMP_W-1:0]   damp_q;
  logic [OSHIFT_W-1:0] oshift_q;

  logic signed [STATE_W-1:0]  bp_q;
  logic signed [STATE_W-1:0]  lp_q;
  logic signed [STATE_W-1:0]  hp_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [ACC_W-1:0]    wrk_q;
  logic signed [ACC_W-1:0]    tmp_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       clip_q;

  alu_ctl_t                alu_ctl;
  logic signed [ACC_W-1:0] alu_a;
  logic signed [ACC_W-1:0] alu_b;
  logic [COEFF_W-1:0]      alu_c;
  logic signed [ACC_W-1:0] alu_res;

  sweep_cfg_t         sweep_cfg;
  logic               advance;
  logic [COEFF_W-1:0] tuning;

  logic signed [ACC_W-1:0]   x_ext;
  logic signed [ACC_W-1:0]   bp_ext;
  logic signed [ACC_W-1:0]   lp_ext;
  logic signed [ACC_W-1:0]   hp_ext;
  logic [AMT_W-1:0]          out_amt;
  logic signed [STATE_W-1:0] out_shifted;
  logic signed [SAMPLE_W-1:0] out_sat;
  logic                      out_clip;
  logic                      in_beat;
  logic                      out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q <= RESET_MIN_FREQ;
      max_freq_q <= RESET_MAX_FREQ;
      step_q     <= RESET_STEP;
      damp_q     <= RESET_DAMP;
      oshift_q   <= RESET_OSHIFT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_FREQ: min_freq_q <= cfg_data_i[FREQ_W-1:0];
        CFG_MAX_FREQ: max_freq_q <= cfg_data_i[FREQ_W-1:0];
        CFG_STEP:     step_q     <= cfg_data_i[STEP_W-1:0];
        CFG_DAMP:     damp_q     <= cfg_data_i[DAMP_W-1:0];
        CFG_OSHIFT:   oshift_q   <= cfg_data_i[OSHIFT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Operands widened to the accumulator; the sample moves to the node's binary point.
  assign x_ext  = {{(ACC_W - SAMPLE_W - SHIFT_BASE){x_q[SAMPLE_W-1]}}, x_q, {SHIFT_BASE{1'b0}}};
  assign bp_ext = {{(ACC_W - STATE_W){bp_q[STATE_W-1]}}, bp_q};
  assign lp_ext = {{(ACC_W - STATE_W){lp_q[STATE_W-1]}}, lp_q};
  assign hp_ext = {{(ACC_W - STATE_W){hp_q[STATE_W-1]}}, hp_q};

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sequencer: next state and operands of the shared unit.
  always_comb begin
    state_d    = state_q;
    alu_ctl.op = ALU_SUB;
    alu_a      = wrk_q;
    alu_b      = bp_ext;
    alu_c      = tuning;
    advance    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d = S_MULD;
        end
      end
      S_MULD: begin
        alu_ctl.op = ALU_MULD;
        alu_a      = bp_ext;
        alu_c      = {{(COEFF_W - DAMP_W){1'b0}}, damp_q};
        state_d    = S_XL;
      end
      S_XL: begin
        alu_ctl.op = ALU_SUB;
        alu_a      = x_ext;
        alu_b      = lp_ext;
        state_d    = S_HP;
      end
      S_HP: begin
        alu_ctl.op = ALU_SUBSAT;
        alu_a      = tmp_q;
        alu_b      = wrk_q;
        state_d    = S_MULF1;
      end
      S_MULF1: begin
        alu_ctl.op = ALU_MULF;
        alu_a      = hp_ext;
        state_d    = S_BP;
      end
      S_BP: begin
        alu_ctl.op = ALU_ADDSAT;
        alu_a      = wrk_q;
        alu_b      = bp_ext;
        state_d    = S_MULF2;
      end
      S_MULF2: begin
        alu_ctl.op = ALU_MULF;
        alu_a      = bp_ext;
        state_d    = S_LP;
      end
      S_LP: begin
        alu_ctl.op = ALU_ADDSAT;
        alu_a      = wrk_q;
        alu_b      = lp_ext;
        advance    = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  swv_alu u_alu (
    .ctl_i (alu_ctl),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .res_o (alu_res)
  );

  assign sweep_cfg.min_freq = min_freq_q;
  assign sweep_cfg.max_freq = max_freq_q;
  assign sweep_cfg.step     = step_q;

  swv_sweep u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (sweep_cfg),
    .advance_i (advance),
    .tuning_o  (tuning)
  );

  // Filter nodes held between samples.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q <= '0;
      lp_q <= '0;
    end else if (state_q == S_BP) begin
      bp_q <= alu_res[STATE_W-1:0];
    end else if (state_q == S_LP) begin
      lp_q <= alu_res[STATE_W-1:0];
    end
  end

  // Working registers of one sample.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      x_q <= sample_in_i;
    end
    if ((state_q == S_MULD) || (state_q == S_MULF1) || (state_q == S_MULF2)) begin
      wrk_q <= alu_res;
    end
    if (state_q == S_XL) begin
      tmp_q <= alu_res;
    end
    if (state_q == S_HP) begin
      hp_q <= alu_res[STATE_W-1:0];
    end
  end

  // Output scaling and saturation to the sample width.
  assign out_amt     = AMT_W'(SHIFT_BASE) + {{(AMT_W - OSHIFT_W){1'b0}}, oshift_q};
  assign out_shifted = bp_q >>> out_amt;

  always_comb begin
    if (out_shifted > STATE_W'((1 << (SAMPLE_W - 1)) - 1)) begin
      out_sat  = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      out_clip = 1'b1;
    end else if (out_shifted < -STATE_W'(1 << (SAMPLE_W - 1))) begin
      out_sat  = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      out_clip = 1'b1;
    end else begin
      out_sat  = out_shifted[SAMPLE_W-1:0];
      out_clip = 1'b0;
    end
  end

  // Output register: the beat waits here while the next sample starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_OUT) && out_free) begin
      out_q  <= out_sat;
      clip_q <= out_clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign clipped_o    = clip_q;

endmodule

// ===== hw/rtl/swv_alu.sv =====
// Shared multiply and saturating add unit of the filter datapath.
module swv_alu import swv_pkg::*; (
  input  alu_ctl_t                  ctl_i,
  input  logic signed [ACC_W-1:0]   a_i,
  input  logic signed [ACC_W-1:0]   b_i,
  input  logic        [COEFF_W-1:0] c_i,
  output logic signed [ACC_W-1:0]   res_o
);

  localparam int PROD_W = STATE_W + COEFF_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  b_eff;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  sum_sat;
  logic                     in_range;

  // Node times coefficient; the floor comes from the arithmetic shift.
  assign prod = $signed(a_i[STATE_W-1:0]) * $signed({1'b0, c_i});

  always_comb begin
    if (ctl_i.op == ALU_MULD) begin
      prod_sh = prod >>> 14;
    end else begin
      prod_sh = prod >>> 16;
    end
  end

  // One adder serves both subtraction and addition.
  assign b_eff = ((ctl_i.op == ALU_SUB) || (ctl_i.op == ALU_SUBSAT)) ? -b_i : b_i;
  assign sum   = a_i + b_eff;

  // Saturate to the signed node width.
  assign in_range = (&sum[ACC_W-1:STATE_W-1]) || !(|sum[ACC_W-1:STATE_W-1]);

  always_comb begin
    if (in_range) begin
      sum_sat = sum;
    end else if (sum[ACC_W-1]) begin
      sum_sat = SAT_NEG;
    end else begin
      sum_sat = SAT_POS;
    end
  end

  // Result select.
  always_comb begin
    case (ctl_i.op)
      ALU_MULD, ALU_MULF:     res_o = prod_sh[ACC_W-1:0];
      ALU_SUB:                res_o = sum;
      ALU_SUBSAT, ALU_ADDSAT: res_o = sum_sat;
      default:                res_o = sum;
    endcase
  end

endmodule

// ===== hw/rtl/swv_sweep.sv =====
// Triangle sweep of the center frequency and the tuning coefficient lookup.
module swv_sweep import swv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sweep_cfg_t         cfg_i,
  input  logic               advance_i,
  output logic [COEFF_W-1:0] tuning_o
);

  localparam int SINE_ENTRIES = (1 << SINE_ADDR_W) + 1;
  localparam int ROM_ADDR_W   = SINE_ADDR_W + 1;
  localparam longint PI_HALF_Q30 = 1686629713;
  localparam longint COEFF_MAX   = 131072;

  typedef logic [COEFF_W-1:0] coeff_rom_t [SINE_ENTRIES];

  // Entry a is 2*sin(pi*f) in Q2.16 from a Q30 Taylor series to x^13.
  function automatic coeff_rom_t build_coeff_rom();
    coeff_rom_t          rom;
    logic        [63:0]  x;
    logic        [63:0]  x2;
    logic        [63:0]  term;
    logic signed [63:0]  s;
    for (int a = 0; a < SINE_ENTRIES; a++) begin
      x    = (64'(PI_HALF_Q30) * 64'(a)) >> SINE_ADDR_W;
      x2   = (x * x) >> 30;
      term = x;
      s    = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      s    = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      s    = s + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      s    = s - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      s    = s + $signed(term);
      if (s < 0) begin
        s = 0;
      end
      if (s > (64'sd1 <<< 30)) begin
        s = 64'sd1 <<< 30;
      end
      s = (s * (64'sd1 <<< 17) + (64'sd1 <<< 29)) >>> 30;
      if (s > COEFF_MAX) begin
        s = COEFF_MAX;
      end
      rom[a] = COEFF_W'(s);
    end
    return rom;
  endfunction

  localparam coeff_rom_t COEFF_ROM = build_coeff_rom();

  localparam logic [ROM_ADDR_W-1:0] RESET_ADDR = RESET_MIN_FREQ[FREQ_W-1] ?
      ROM_ADDR_W'(1 << SINE_ADDR_W) :
      {1'b0, RESET_MIN_FREQ[FREQ_W-2 -: SINE_ADDR_W]};

  logic [FREQ_W-1:0]     freq_q, freq_d;
  logic                  down_q, down_d;
  logic [COEFF_W-1:0]    tuning_q, tuning_d;
  logic [COEFF_W-1:0]    rom_q;
  logic [ROM_ADDR_W-1:0] rom_addr;
  logic [FREQ_W:0]       up_next;
  logic [FREQ_W:0]       down_floor;

  // Frequencies of one half and above map to the top entry.
  assign rom_addr = freq_q[FREQ_W-1] ? ROM_ADDR_W'(1 << SINE_ADDR_W) :
                                       {1'b0, freq_q[FREQ_W-2 -: SINE_ADDR_W]};

  // Registered table read; the frequency changes only once per sample.
  always_ff @(posedge clk_i) begin
    rom_q <= COEFF_ROM[rom_addr];
  end

  // Next sweep point, snapping to a bound where the direction turns.
  assign up_next    = {1'b0, freq_q} + {{(FREQ_W - STEP_W + 1){1'b0}}, cfg_i.step};
  assign down_floor = {1'b0, cfg_i.min_freq} + {{(FREQ_W - STEP_W + 1){1'b0}}, cfg_i.step};

  always_comb begin
    freq_d   = freq_q;
    down_d   = down_q;
    tuning_d = tuning_q;
    if (advance_i) begin
      tuning_d = rom_q;
      if (!down_q) begin
        if (up_next > {1'b0, cfg_i.max_freq}) begin
          freq_d = cfg_i.max_freq;
          down_d = 1'b1;
        end else begin
          freq_d = up_next[FREQ_W-1:0];
        end
      end else begin
        if ({1'b0, freq_q} < down_floor) begin
          freq_d = cfg_i.min_freq;
          down_d = 1'b0;
        end else begin
          freq_d = freq_q - {{(FREQ_W - STEP_W){1'b0}}, cfg_i.step};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q   <= RESET_MIN_FREQ;
      down_q   <= 1'b0;
      tuning_q <= COEFF_ROM[RESET_ADDR];
    end else begin
      freq_q   <= freq_d;
      down_q   <= down_d;
      tuning_q <= tuning_d;
    end
  end

  assign tuning_o = tuning_q;

endmodule
